// ----- rtl/clipped_sprite_blit_macros.svh -----
// Assertion macros used by the sprite blitter RTL.
// Each macro expects clk and rst_n to be visible where it is used.
`ifndef CLIPPED_SPRITE_BLIT_MACROS_SVH
`define CLIPPED_SPRITE_BLIT_MACROS_SVH

// Antecedent implies consequent in the same cycle.
`define CSB_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Antecedent implies consequent in the following cycle.
`define CSB_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- rtl/csb_pkg.sv -----
// Package for the clipped sprite blitter: widths, reset values, register
// indexes and the control struct passed between pipeline stages. No dependencies.
package csb_pkg;

    // Fixed field widths.
    localparam int DIM_W      = 13;
    localparam int POS_W      = 16;
    localparam int SPEED_W    = 11;
    localparam int ADDR_W     = 24;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;
    localparam int ACC_W      = 32;

    // Defaults for the top-level parameters.
    localparam int DEFAULT_MAX_DIM    = 4096;
    localparam int DEFAULT_PIXEL_BITS = 32;

    // Register reset values.
    localparam logic [DIM_W-1:0] RST_SPRITE_WIDTH  = 13'd1;
    localparam logic [DIM_W-1:0] RST_SPRITE_HEIGHT = 13'd1;
    localparam logic [DIM_W-1:0] RST_FRAME_WIDTH   = 13'd640;
    localparam logic [DIM_W-1:0] RST_FRAME_HEIGHT  = 13'd480;

    // Configuration register indexes.
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_SPRITE_WIDTH  = 3'd0,
        REG_SPRITE_HEIGHT = 3'd1,
        REG_FRAME_WIDTH   = 3'd2,
        REG_FRAME_HEIGHT  = 3'd3,
        REG_START_X       = 3'd4,
        REG_START_Y       = 3'd5,
        REG_SPEED_X       = 3'd6,
        REG_SPEED_Y       = 3'd7
    } cfg_reg_t;

    // Control bits of the position stage, handed to the address stage.
    typedef struct packed {
        logic valid;
        logic in_frame;
        logic done;
    } csb_ctl_t;

endpackage

// ----- rtl/csb_addr.sv -----
// Address stage of the sprite blitter: forms y*frame_width+x and holds the
// output register. Depends on csb_pkg.
module csb_addr #(
    parameter int PIXEL_BITS = csb_pkg::DEFAULT_PIXEL_BITS
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  csb_pkg::csb_ctl_t           s1_ctl,
    input  logic [csb_pkg::DIM_W-1:0]   s1_x,
    input  logic [csb_pkg::DIM_W-1:0]   s1_y,
    input  logic [PIXEL_BITS-1:0]       s1_pixel,
    input  logic [csb_pkg::DIM_W-1:0]   frame_width,
    input  logic                        out_ready,
    output logic                        out_valid,
    output logic                        write_enable,
    output logic [csb_pkg::ADDR_W-1:0]  write_address,
    output logic [PIXEL_BITS-1:0]       pixel_out,
    output logic                        sprite_done,
    output logic                        advance
);
    import csb_pkg::*;

    logic                    out_valid_reg;
    logic                    we_reg;
    logic [ADDR_W-1:0]       addr_reg;
    logic [PIXEL_BITS-1:0]   pixel_reg;
    logic                    done_reg;

    logic [2*DIM_W-1:0]      product;
    logic [2*DIM_W:0]        linear;
    logic [ADDR_W-1:0]       addr_next;
    logic [PIXEL_BITS-1:0]   pixel_next;

    // The output register moves when it is empty or being drained.
    assign advance = !out_valid_reg || out_ready;

    // Linear address; suppressed writes give zero address and zero word.
    always_comb
    begin
        product    = s1_y * frame_width;
        linear     = {1'b0, product} + (2*DIM_W+1)'(s1_x);
        addr_next  = s1_ctl.in_frame ? linear[ADDR_W-1:0] : '0;
        pixel_next = s1_ctl.in_frame ? s1_pixel : '0;
    end

    // Output valid flag.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= s1_ctl.valid;
        end
    end

    // Output payload.
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            we_reg    <= s1_ctl.in_frame;
            addr_reg  <= addr_next;
            pixel_reg <= pixel_next;
            done_reg  <= s1_ctl.done;
        end
    end

    assign out_valid     = out_valid_reg;
    assign write_enable  = we_reg;
    assign write_address = addr_reg;
    assign pixel_out     = pixel_reg;
    assign sprite_done   = done_reg;

endmodule

// ----- rtl/clipped_sprite_blit.sv -----
// Clipped sprite blitter: an accepted word goes through the position stage
// (counter and 32-bit adders) and then the 13x13 address multiply stage to its
// result word on the output; throughput is one word per cycle while the output
// is not stalled. Stall on the output backs up through both stages with no loss.
// Asynchronous active-low reset loads the register defaults, clears the
// sprite counters and motion offsets, and empties the pipeline.
module clipped_sprite_blit #(
    parameter int MAX_DIM    = csb_pkg::DEFAULT_MAX_DIM,
    parameter int PIXEL_BITS = csb_pkg::DEFAULT_PIXEL_BITS
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_write,
    input  logic [csb_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [csb_pkg::CFG_DATA_W-1:0]  cfg_data,
    input  logic                            in_valid,
    output logic                            in_ready,
    input  logic [PIXEL_BITS-1:0]           pixel_in,
    output logic                            out_valid,
    input  logic                            out_ready,
    output logic                            write_enable,
    output logic [csb_pkg::ADDR_W-1:0]      write_address,
    output logic [PIXEL_BITS-1:0]           pixel_out,
    output logic                            sprite_done
);
    import csb_pkg::*;

`include "clipped_sprite_blit_macros.svh"

    localparam int CW = $clog2(MAX_DIM);
    localparam int EW = (CW + 1 > DIM_W) ? CW + 1 : DIM_W;

    // Configuration registers.
    logic [DIM_W-1:0]    sprite_width_reg;
    logic [DIM_W-1:0]    sprite_height_reg;
    logic [DIM_W-1:0]    frame_width_reg;
    logic [DIM_W-1:0]    frame_height_reg;
    logic [POS_W-1:0]    start_x_reg;
    logic [POS_W-1:0]    start_y_reg;
    logic [SPEED_W-1:0]  speed_x_reg;
    logic [SPEED_W-1:0]  speed_y_reg;

    // Sprite walk state.
    logic [CW-1:0]       col_reg;
    logic [CW-1:0]       row_reg;
    logic [ACC_W-1:0]    offset_x_reg;
    logic [ACC_W-1:0]    offset_y_reg;
    logic [CW-1:0]       col_next;
    logic [CW-1:0]       row_next;
    logic [ACC_W-1:0]    offset_x_next;
    logic [ACC_W-1:0]    offset_y_next;

    // Position stage register.
    csb_ctl_t               s1_ctl_reg;
    logic [DIM_W-1:0]       s1_x_reg;
    logic [DIM_W-1:0]       s1_y_reg;
    logic [PIXEL_BITS-1:0]  s1_pixel_reg;

    logic            s1_en;
    logic            in_fire;
    logic            s2_advance;
    logic [EW-1:0]   sw_ext;
    logic [EW-1:0]   sh_ext;
    logic [EW-1:0]   w_eff;
    logic [EW-1:0]   h_eff;
    logic [EW-1:0]   col_inc;
    logic [EW-1:0]   row_inc;
    logic            col_wrap;
    logic            row_wrap;
    logic            done;
    logic [ACC_W-1:0] pos_x;
    logic [ACC_W-1:0] pos_y;
    logic            in_frame;

    // The position stage takes a word whenever it can hand its own one on.
    assign s1_en    = !s1_ctl_reg.valid || s2_advance;
    assign in_ready = s1_en;
    assign in_fire  = in_valid && s1_en;

    // Configuration writes.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sprite_width_reg  <= RST_SPRITE_WIDTH;
            sprite_height_reg <= RST_SPRITE_HEIGHT;
            frame_width_reg   <= RST_FRAME_WIDTH;
            frame_height_reg  <= RST_FRAME_HEIGHT;
            start_x_reg       <= '0;
            start_y_reg       <= '0;
            speed_x_reg       <= '0;
            speed_y_reg       <= '0;
        end
        else if (cfg_write)
        begin
            case (cfg_reg_t'(cfg_index))
                REG_SPRITE_WIDTH:  sprite_width_reg  <= cfg_data[DIM_W-1:0];
                REG_SPRITE_HEIGHT: sprite_height_reg <= cfg_data[DIM_W-1:0];
                REG_FRAME_WIDTH:   frame_width_reg   <= cfg_data[DIM_W-1:0];
                REG_FRAME_HEIGHT:  frame_height_reg  <= cfg_data[DIM_W-1:0];
                REG_START_X:       start_x_reg       <= cfg_data[POS_W-1:0];
                REG_START_Y:       start_y_reg       <= cfg_data[POS_W-1:0];
                REG_SPEED_X:       speed_x_reg       <= cfg_data[SPEED_W-1:0];
                REG_SPEED_Y:       speed_y_reg       <= cfg_data[SPEED_W-1:0];
                default:           ;
            endcase
        end
    end

    // Effective sprite size: zero acts as one, large sizes saturate.
    always_comb
    begin
        sw_ext = EW'(sprite_width_reg);
        sh_ext = EW'(sprite_height_reg);
        if (sw_ext == '0)
            w_eff = EW'(1);
        else if (sw_ext > EW'(MAX_DIM))
            w_eff = EW'(MAX_DIM);
        else
            w_eff = sw_ext;
        if (sh_ext == '0)
            h_eff = EW'(1);
        else if (sh_ext > EW'(MAX_DIM))
            h_eff = EW'(MAX_DIM);
        else
            h_eff = sh_ext;
    end

    // Counter stepping and motion update at the end of each sprite.
    always_comb
    begin
        col_inc       = EW'(col_reg) + EW'(1);
        row_inc       = EW'(row_reg) + EW'(1);
        col_wrap      = col_inc >= w_eff;
        row_wrap      = row_inc >= h_eff;
        done          = col_wrap && row_wrap;
        col_next      = col_wrap ? '0 : col_inc[CW-1:0];
        row_next      = row_reg;
        offset_x_next = offset_x_reg;
        offset_y_next = offset_y_reg;
        if (col_wrap)
        begin
            row_next = row_wrap ? '0 : row_inc[CW-1:0];
        end
        if (done)
        begin
            offset_x_next = offset_x_reg + {{(ACC_W-SPEED_W){speed_x_reg[SPEED_W-1]}}, speed_x_reg};
            offset_y_next = offset_y_reg + {{(ACC_W-SPEED_W){speed_y_reg[SPEED_W-1]}}, speed_y_reg};
        end
    end

    // Frame position; negative values are huge unsigned and fail the bound test.
    always_comb
    begin
        pos_x    = {{(ACC_W-POS_W){start_x_reg[POS_W-1]}}, start_x_reg} + offset_x_reg
                   + ACC_W'(col_reg);
        pos_y    = {{(ACC_W-POS_W){start_y_reg[POS_W-1]}}, start_y_reg} + offset_y_reg
                   + ACC_W'(row_reg);
        in_frame = (pos_x < ACC_W'(frame_width_reg)) && (pos_y < ACC_W'(frame_height_reg));
    end

    // Walk state registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg      <= '0;
            row_reg      <= '0;
            offset_x_reg <= '0;
            offset_y_reg <= '0;
        end
        else if (in_fire)
        begin
            col_reg      <= col_next;
            row_reg      <= row_next;
            offset_x_reg <= offset_x_next;
            offset_y_reg <= offset_y_next;
        end
    end

    // Position stage control.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_ctl_reg <= '0;
        end
        else if (s1_en)
        begin
            s1_ctl_reg.valid    <= in_valid;
            s1_ctl_reg.in_frame <= in_frame;
            s1_ctl_reg.done     <= done;
        end
    end

    // Position stage payload; an in-frame position fits the frame width.
    always_ff @(posedge clk)
    begin
        if (s1_en)
        begin
            s1_x_reg     <= pos_x[DIM_W-1:0];
            s1_y_reg     <= pos_y[DIM_W-1:0];
            s1_pixel_reg <= pixel_in;
        end
    end

    csb_addr #(
        .PIXEL_BITS (PIXEL_BITS)
    ) u_addr (
        .clk           (clk),
        .rst_n         (rst_n),
        .s1_ctl        (s1_ctl_reg),
        .s1_x          (s1_x_reg),
        .s1_y          (s1_y_reg),
        .s1_pixel      (s1_pixel_reg),
        .frame_width   (frame_width_reg),
        .out_ready     (out_ready),
        .out_valid     (out_valid),
        .write_enable  (write_enable),
        .write_address (write_address),
        .pixel_out     (pixel_out),
        .sprite_done   (sprite_done),
        .advance       (s2_advance)
    );

    // A suppressed write carries a zero address and a zero word.
    `CSB_ASSERT_SAME(a_suppress_zero, out_valid && !write_enable,
        write_address == '0 && pixel_out == '0, "suppressed write with nonzero payload")

    // A full pipeline facing a stalled output takes no new word.
    `CSB_ASSERT_SAME(a_full_stall, s1_ctl_reg.valid && out_valid && !out_ready,
        !in_ready, "word accepted into a full pipeline")

    // The last pixel of a sprite returns both counters to the origin.
    `CSB_ASSERT_NEXT(a_done_clears, in_fire && done,
        col_reg == '0 && row_reg == '0, "counters not cleared after sprite end")

endmodule

// ----- tb/clipped_sprite_blit_test.sv -----
// Self-checking testbench for the clipped sprite blitter: streams pixel words
// through the block with random idling on both sides and checks each result word.
// Depends on csb_pkg and the clipped_sprite_blit RTL.
module clipped_sprite_blit_test;
    import csb_pkg::*;

    localparam int PIX_W        = DEFAULT_PIXEL_BITS;
    localparam int SIZE_CAP     = DEFAULT_MAX_DIM;
    localparam int CYCLE_LIMIT  = 400000;
    localparam int DRAIN_CYCLES = 6;
    localparam int RANDOM_WORDS = 900;

    // One framebuffer write as the block should present it.
    typedef struct packed {
        logic              we;
        logic [ADDR_W-1:0] addr;
        logic [PIX_W-1:0]  pixel;
        logic              done;
    } blit_write_t;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  cfg_write = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;
    logic                  in_valid = 1'b0;
    logic                  in_ready;
    logic [PIX_W-1:0]      pixel_in = '0;
    logic                  out_valid;
    logic                  out_ready = 1'b0;
    logic                  write_enable;
    logic [ADDR_W-1:0]     write_address;
    logic [PIX_W-1:0]      pixel_out;
    logic                  sprite_done;

    // Register copies and sprite/motion state of the predictor.
    logic [DIM_W-1:0]   sprite_w_reg;
    logic [DIM_W-1:0]   sprite_h_reg;
    logic [DIM_W-1:0]   frame_w_reg;
    logic [DIM_W-1:0]   frame_h_reg;
    logic [POS_W-1:0]   start_x_reg;
    logic [POS_W-1:0]   start_y_reg;
    logic [SPEED_W-1:0] speed_x_reg;
    logic [SPEED_W-1:0] speed_y_reg;
    logic [31:0]        col_pos;
    logic [31:0]        row_pos;
    logic [31:0]        offset_x;
    logic [31:0]        offset_y;

    logic [PIX_W-1:0] pixel_queue[$];
    blit_write_t      expected_writes[$];
    blit_write_t      want;
    int               issued_count = 0;
    int               accepted_count = 0;
    int               fail_count = 0;
    int               cycle_count = 0;
    int               idle_mode = 0;
    int               send_gap = 0;
    int               recv_stall = 0;

    clipped_sprite_blit dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_write     (cfg_write),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .pixel_in      (pixel_in),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .write_enable  (write_enable),
        .write_address (write_address),
        .pixel_out     (pixel_out),
        .sprite_done   (sprite_done)
    );

    always #5 clk = ~clk;

    // Zero acts as one, anything above the cap saturates.
    function automatic logic [31:0] clamp_dim(input logic [DIM_W-1:0] v);
        if (v == '0)
            return 32'd1;
        if (v > SIZE_CAP)
            return SIZE_CAP;
        return 32'(v);
    endfunction

    // Works out the write for one pixel word and advances the sprite position.
    function automatic blit_write_t blit_pixel(input logic [PIX_W-1:0] pix);
        logic [31:0] x_pos;
        logic [31:0] y_pos;
        logic [31:0] w_eff;
        logic [31:0] h_eff;
        logic [63:0] linear;
        logic        in_frame;
        blit_write_t res;
        w_eff = clamp_dim(sprite_w_reg);
        h_eff = clamp_dim(sprite_h_reg);
        x_pos = {{(32-POS_W){start_x_reg[POS_W-1]}}, start_x_reg} + offset_x + col_pos;
        y_pos = {{(32-POS_W){start_y_reg[POS_W-1]}}, start_y_reg} + offset_y + row_pos;
        // Negative positions compare as huge unsigned values.
        in_frame = (x_pos < 32'(frame_w_reg)) && (y_pos < 32'(frame_h_reg));
        linear = 64'(y_pos) * 64'(frame_w_reg) + 64'(x_pos);
        res.we = in_frame;
        res.addr = in_frame ? linear[ADDR_W-1:0] : '0;
        res.pixel = in_frame ? pix : '0;
        res.done = 1'b0;
        if (col_pos + 1 >= w_eff)
        begin
            col_pos = 0;
            if (row_pos + 1 >= h_eff)
            begin
                row_pos = 0;
                res.done = 1'b1;
                offset_x = offset_x + {{(32-SPEED_W){speed_x_reg[SPEED_W-1]}}, speed_x_reg};
                offset_y = offset_y + {{(32-SPEED_W){speed_y_reg[SPEED_W-1]}}, speed_y_reg};
            end
            else
                row_pos = row_pos + 1;
        end
        else
            col_pos = col_pos + 1;
        return res;
    endfunction

    // Idle length: none in mode 0; otherwise none, short or a few long, fewer none in mode 2.
    function automatic int pick_gap(input int mode);
        int roll;
        if (mode == 0)
            return 0;
        roll = $urandom_range(99);
        if (roll < 85 - 25 * mode)
            return 0;
        if (roll < 94)
            return $urandom_range(3, 1);
        return $urandom_range(30, 6);
    endfunction

    // Random register value: small sizes and positions near the frame, rare extremes.
    function automatic logic [CFG_DATA_W-1:0] pick_reg_value(input cfg_reg_t idx);
        int                    roll;
        logic [CFG_DATA_W-1:0] near;
        roll = $urandom_range(99);
        case (idx)
            REG_SPRITE_WIDTH, REG_SPRITE_HEIGHT, REG_FRAME_WIDTH, REG_FRAME_HEIGHT:
            begin
                if (roll < 4)
                    return '0;
                if (roll < 7)
                    return CFG_DATA_W'(SIZE_CAP);
                if (roll < 9)
                    return {3'($urandom), 13'h1FFF};
                if (idx == REG_FRAME_WIDTH || idx == REG_FRAME_HEIGHT)
                    return CFG_DATA_W'($urandom_range(24, 1));
                return CFG_DATA_W'($urandom_range(6, 1));
            end
            REG_START_X, REG_START_Y:
            begin
                if (roll < 5)
                    return 16'h8000;
                if (roll < 10)
                    return 16'h7FFF;
                // Pull the sprite back near the frame despite accumulated motion.
                near = (idx == REG_START_X) ? offset_x[15:0] : offset_y[15:0];
                if (roll < 70)
                    return CFG_DATA_W'($urandom_range(20)) - 16'd4 - near;
                return CFG_DATA_W'($urandom_range(24)) - 16'd8;
            end
            default:
            begin
                if (roll < 6)
                    return {5'($urandom), 11'h400};
                if (roll < 12)
                    return {5'($urandom), 11'h3FF};
                return {5'($urandom), 11'($urandom_range(6)) - 11'd3};
            end
        endcase
    endfunction

    // Register write; the predictor copy follows at once since the block is idle.
    task automatic write_reg(input cfg_reg_t idx, input logic [CFG_DATA_W-1:0] val);
        @(posedge clk);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        case (idx)
            REG_SPRITE_WIDTH:  sprite_w_reg = val[DIM_W-1:0];
            REG_SPRITE_HEIGHT: sprite_h_reg = val[DIM_W-1:0];
            REG_FRAME_WIDTH:   frame_w_reg = val[DIM_W-1:0];
            REG_FRAME_HEIGHT:  frame_h_reg = val[DIM_W-1:0];
            REG_START_X:       start_x_reg = val;
            REG_START_Y:       start_y_reg = val;
            REG_SPEED_X:       speed_x_reg = val[SPEED_W-1:0];
            default:           speed_y_reg = val[SPEED_W-1:0];
        endcase
    endtask

    task automatic end_config();
        @(posedge clk);
        cfg_write <= 1'b0;
    endtask

    task automatic push_pixel(input logic [PIX_W-1:0] v);
        pixel_queue.push_back(v);
        issued_count++;
    endtask

    // Wait until every word is taken and every result has come, then let the pipe settle.
    task automatic drain();
        while (accepted_count != issued_count || expected_writes.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // Input driver: presents queued pixel words with random gaps.
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            send_gap = 0;
        end
        else
        begin
            if (in_valid && in_ready)
            begin
                expected_writes.push_back(blit_pixel(pixel_in));
                accepted_count++;
            end
            if (!in_valid || in_ready)
            begin
                if (send_gap > 0)
                begin
                    send_gap--;
                    in_valid <= 1'b0;
                end
                else if (pixel_queue.size() != 0)
                begin
                    in_valid <= 1'b1;
                    pixel_in <= pixel_queue.pop_front();
                    send_gap = pick_gap(idle_mode);
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    // Output monitor: random back-pressure and field-by-field checks.
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            out_ready <= 1'b0;
            recv_stall = 0;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                if (expected_writes.size() == 0)
                begin
                    $error("result word with no expected result waiting");
                    fail_count++;
                end
                else
                begin
                    want = expected_writes.pop_front();
                    if (write_enable !== want.we)
                    begin
                        $error("write_enable: expected %0d, got %0d", want.we, write_enable);
                        fail_count++;
                    end
                    if (write_address !== want.addr)
                    begin
                        $error("write_address: expected %0h, got %0h", want.addr,
                               write_address);
                        fail_count++;
                    end
                    if (pixel_out !== want.pixel)
                    begin
                        $error("pixel_out: expected %0h, got %0h", want.pixel, pixel_out);
                        fail_count++;
                    end
                    if (sprite_done !== want.done)
                    begin
                        $error("sprite_done: expected %0d, got %0d", want.done, sprite_done);
                        fail_count++;
                    end
                end
            end
            if (recv_stall > 0)
            begin
                recv_stall--;
                out_ready <= 1'b0;
            end
            else
            begin
                out_ready <= 1'b1;
                recv_stall = pick_gap(idle_mode);
            end
        end
    end

    // Watchdog.
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    // Stimulus: directed settings first, then random phases.
    initial
    begin
        int       n;
        int       half;
        int       random_sent;
        cfg_reg_t idx;
        sprite_w_reg = RST_SPRITE_WIDTH;
        sprite_h_reg = RST_SPRITE_HEIGHT;
        frame_w_reg = RST_FRAME_WIDTH;
        frame_h_reg = RST_FRAME_HEIGHT;
        start_x_reg = '0;
        start_y_reg = '0;
        speed_x_reg = '0;
        speed_y_reg = '0;
        col_pos = 0;
        row_pos = 0;
        offset_x = 0;
        offset_y = 0;
        random_sent = 0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        // Reset values: a 1x1 sprite at the origin of a 640x480 frame.
        push_pixel('0);
        push_pixel('1);
        drain();

        // Sprite hanging off the left edge, moving right and down into the corner.
        write_reg(REG_SPRITE_WIDTH, 16'd3);
        write_reg(REG_SPRITE_HEIGHT, 16'd2);
        write_reg(REG_FRAME_WIDTH, 16'd4);
        write_reg(REG_FRAME_HEIGHT, 16'd3);
        write_reg(REG_START_X, 16'hFFFF);
        write_reg(REG_START_Y, 16'd0);
        write_reg(REG_SPEED_X, 16'd2);
        write_reg(REG_SPEED_Y, 16'd1);
        end_config();
        idle_mode = 1;
        repeat (12) push_pixel($urandom);
        drain();

        // Zero sprite size acts as one; a zero frame never takes a write.
        write_reg(REG_SPRITE_WIDTH, 16'd0);
        write_reg(REG_SPRITE_HEIGHT, 16'd0);
        write_reg(REG_FRAME_WIDTH, 16'd0);
        write_reg(REG_FRAME_HEIGHT, 16'd0);
        write_reg(REG_SPEED_X, 16'd0);
        write_reg(REG_SPEED_Y, 16'd0);
        end_config();
        repeat (3) push_pixel($urandom);
        drain();

        // Largest frame: the linear address runs past 24 bits. Extreme speeds.
        write_reg(REG_SPRITE_WIDTH, 16'd4);
        write_reg(REG_SPRITE_HEIGHT, 16'd1);
        write_reg(REG_FRAME_WIDTH, 16'h1FFF);
        write_reg(REG_FRAME_HEIGHT, 16'h1FFF);
        write_reg(REG_START_X, 16'(8183));
        write_reg(REG_START_Y, 16'(8186));
        write_reg(REG_SPEED_X, 16'h03FF);
        write_reg(REG_SPEED_Y, 16'h0400);
        end_config();
        push_pixel('1);
        repeat (3) push_pixel($urandom);
        drain();

        // Oversized sprite saturates; start at the most negative position.
        write_reg(REG_SPRITE_WIDTH, 16'h1FFF);
        write_reg(REG_SPRITE_HEIGHT, 16'd4096);
        write_reg(REG_START_X, 16'h8000);
        end_config();
        repeat (2) push_pixel($urandom);
        drain();

        // Shrink the sprite while the column counter is past the new width.
        write_reg(REG_SPRITE_WIDTH, 16'd2);
        write_reg(REG_SPRITE_HEIGHT, 16'd1);
        write_reg(REG_START_X, 16'h7FFF);
        end_config();
        repeat (2) push_pixel($urandom);
        drain();

        // Random phases, each a new mix of settings and idling.
        while (random_sent < RANDOM_WORDS)
        begin
            for (int i = 0; i < 8; i++)
            begin
                idx = cfg_reg_t'(i);
                if ($urandom_range(1) == 1)
                    write_reg(idx, pick_reg_value(idx));
            end
            end_config();
            idle_mode = $urandom_range(2);
            n = $urandom_range(60, 5);
            half = ($urandom_range(3) == 0) ? n / 2 : n;
            repeat (half) push_pixel($urandom);
            if (half != n)
            begin
                // Sender holds off until the block has delivered everything.
                while (accepted_count != issued_count || expected_writes.size() != 0)
                    @(posedge clk);
                repeat (n - half) push_pixel($urandom);
            end
            random_sent += n;
            drain();
        end

        if (fail_count == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
